@@ hw/rtl/mspt_pkg.sv @@
// ----------------------------------------------------------------------------
// mspt_pkg
// Shared constants, codes and controller/datapath command types.
// ----------------------------------------------------------------------------
package mspt_pkg;

    localparam int SLOTS   = 8;
    localparam int SLOT_W  = 3;
    localparam int PIN_W   = 8;
    localparam int TIME_W  = 32;
    localparam int IN_W    = 2 + PIN_W + 1 + TIME_W + SLOT_W + TIME_W;
    localparam int IN_BYTES_W = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W   = 1 + PIN_W + 1 + SLOT_W + 2 + 1 + TIME_W + 1;
    localparam int OUT_BYTES_W = ((OUT_W + 7) / 8) * 8;
    localparam logic [TIME_W-1:0] NONE_LEFT = '1;

    localparam logic [1:0] CMD_TRIGGER = 2'd0;
    localparam logic [1:0] CMD_CANCEL  = 2'd1;
    localparam logic [1:0] CMD_TICK    = 2'd2;
    localparam logic [1:0] CMD_QUERY   = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_SLOT  = 2'd1;
    localparam logic [1:0] ST_ZERO_DUR = 2'd2;
    localparam logic [1:0] ST_INACTIVE = 2'd3;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [PIN_W-1:0]  pin;
        logic              level;
        logic [TIME_W-1:0] pulse_len;
        logic [SLOT_W-1:0] slot;
        logic [TIME_W-1:0] elapsed_ms;
    } t_req;

    // controller -> datapath
    typedef struct packed {
        logic              load;      // capture request
        logic              exec;      // trigger/cancel/query, write state
        logic              scan_clr;  // start expiry scan
        logic              scan_step; // compare slot at scan index
        logic              pick;      // expire chosen slot, emit
        logic              age;       // subtract elapsed from survivors
        logic              idle_tick; // tick result without expiry
        logic              min_clr;   // start min scan
        logic              min_step;  // compare slot at scan index
        logic              emit_last; // release result with least time
    } t_ctl;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] cmd;
        logic       found;    // scan found an unreported due slot
        logic       any_due;  // expiry already reported in this tick
        logic       scan_end; // scan index at last slot
    } t_sts;

endpackage

@@ hw/rtl/multi_slot_pulse_timer_unit.sv @@
// ----------------------------------------------------------------------------
// multi_slot_pulse_timer_unit
// Eight-slot one-shot pulse timer with ordered expiry reporting.
// ----------------------------------------------------------------------------
// A request passes decode, execution or the expiry walk, then a least-time scan.
// One request at a time, held off by the 8-slot walk and the result queue.
// Results of a tick are queued and released together once the walk ends.
// Reset: synchronous active low; all slots inactive, no result pending.
module multi_slot_pulse_timer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // cmd[1:0], pin[9:2], level[10], pulse_len[42:11], slot[45:43],
    // elapsed_ms[77:46], zero fill
    input  logic [mspt_pkg::IN_BYTES_W-1:0]  s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // pin_write[0], pin_out[8:1], pin_level[9], slot_id[12:10], status[14:13],
    // any_expired[15], remaining_ms[47:16], slot_active[48], zero fill
    output logic [mspt_pkg::OUT_BYTES_W-1:0] m_axis_tdata,
    output logic        m_axis_tlast
);
    import mspt_pkg::*;

    t_req  req;
    t_ctl  ctl;
    t_sts  sts;
    logic [OUT_W-1:0]  res, qres;
    logic [TIME_W-1:0] rem;
    logic  c_ready, c_valid, c_last, q_busy;
    logic  r_pend;

    assign req.cmd         = s_axis_tdata[1:0];
    assign req.pin         = s_axis_tdata[9:2];
    assign req.level       = s_axis_tdata[10];
    assign req.pulse_len   = s_axis_tdata[42:11];
    assign req.slot        = s_axis_tdata[45:43];
    assign req.elapsed_ms  = s_axis_tdata[77:46];

    assign s_axis_tready = c_ready && !q_busy;

    mspt_controller u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req_valid(s_axis_tvalid && !q_busy), .o_req_ready(c_ready),
        .i_res_ready(1'b1), .o_res_valid(c_valid), .o_res_last(c_last),
        .i_sts(sts), .o_ctl(ctl)
    );

    mspt_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req), .i_ctl(ctl),
        .o_sts(sts), .o_res(res), .o_rem(rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_pend <= 1'b0;
        else          r_pend <= ctl.pick;
    end

    mspt_out_queue u_q (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(r_pend || (c_valid && c_last && !(sts.cmd == CMD_TICK && sts.any_due))),
        .i_res(res), .i_final(c_valid && c_last), .i_rem(rem),
        .o_busy(q_busy), .o_tvalid(m_axis_tvalid), .i_tready(m_axis_tready),
        .o_res(qres), .o_last(m_axis_tlast)
    );

    assign m_axis_tdata = {{(OUT_BYTES_W - OUT_W){1'b0}}, qres};

endmodule

@@ hw/rtl/mspt_datapath.sv @@
// ----------------------------------------------------------------------------
// mspt_datapath
// Slot state, per-slot walk for expiry ordering and least-time scan.
// ----------------------------------------------------------------------------
module mspt_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mspt_pkg::t_req        i_req,
    input  mspt_pkg::t_ctl        i_ctl,
    output mspt_pkg::t_sts        o_sts,
    output logic [mspt_pkg::OUT_W-1:0] o_res,
    output logic [mspt_pkg::TIME_W-1:0] o_rem
);
    import mspt_pkg::*;

    t_req               r_req;
    logic [SLOTS-1:0]   r_act, r_done;
    logic [PIN_W-1:0]   r_pin [SLOTS];
    logic               r_lvl [SLOTS];
    logic [TIME_W-1:0]  r_tl  [SLOTS];
    logic [SLOT_W-1:0]  r_idx, r_best;
    logic               r_found, r_any;
    logic [TIME_W-1:0]  r_bval, r_min;

    logic               r_wr, r_plvl, r_sact;
    logic [PIN_W-1:0]   r_pout;
    logic [SLOT_W-1:0]  r_sid;
    logic [1:0]         r_st;

    logic [SLOT_W-1:0]  free_idx;
    logic               free_ok;
    logic               due, sel_ok;

    always_comb begin
        free_idx = '0;
        free_ok  = 1'b0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_act[i]) begin
                free_idx = SLOT_W'(i);
                free_ok  = 1'b1;
            end
        end
    end

    assign due    = r_act[r_idx] && !r_done[r_idx] && (r_tl[r_idx] <= r_req.elapsed_ms);
    assign sel_ok = r_act[r_best] && !r_done[r_best];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= '0;
        end else begin
            if (i_ctl.exec) begin
                if (r_req.cmd == CMD_TRIGGER && r_req.pulse_len != '0 && free_ok)
                    r_act[free_idx] <= 1'b1;
                else if (r_req.cmd == CMD_CANCEL)
                    r_act[r_req.slot] <= 1'b0;
            end
            if (i_ctl.pick)
                r_act[r_best] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_req  <= i_req;
            r_done <= '0;
            r_any  <= 1'b0;
        end
        if (i_ctl.exec) begin
            r_wr   <= 1'b0;
            r_pout <= '0;
            r_plvl <= 1'b0;
            r_sid  <= r_req.slot;
            r_st   <= ST_OK;
            r_sact <= 1'b0;
            case (r_req.cmd)
                CMD_TRIGGER: begin
                    r_sid <= '0;
                    if (r_req.pulse_len == '0) begin
                        r_st <= ST_ZERO_DUR;
                    end else if (!free_ok) begin
                        r_st <= ST_NO_SLOT;
                    end else begin
                        r_pin[free_idx] <= r_req.pin;
                        r_lvl[free_idx] <= ~r_req.level;
                        r_tl[free_idx]  <= r_req.pulse_len;
                        r_wr   <= 1'b1;
                        r_pout <= r_req.pin;
                        r_plvl <= r_req.level;
                        r_sid  <= free_idx;
                    end
                end
                CMD_CANCEL: begin
                    if (r_act[r_req.slot]) begin
                        r_wr   <= 1'b1;
                        r_pout <= r_pin[r_req.slot];
                        r_plvl <= r_lvl[r_req.slot];
                    end else begin
                        r_st <= ST_INACTIVE;
                    end
                end
                CMD_QUERY: r_sact <= r_act[r_req.slot];
                default: ;
            endcase
        end
        if (i_ctl.scan_clr || i_ctl.min_clr) begin
            r_idx   <= '0;
            r_found <= 1'b0;
            r_min   <= NONE_LEFT;
        end
        if (i_ctl.scan_step) begin
            r_idx <= r_idx + 1'b1;
            if (due && (!r_found || r_tl[r_idx] < r_bval)) begin
                r_found <= 1'b1;
                r_best  <= r_idx;
                r_bval  <= r_tl[r_idx];
            end
        end
        if (i_ctl.pick) begin
            r_done[r_best] <= 1'b1;
            r_any  <= 1'b1;
            r_wr   <= 1'b1;
            r_pout <= r_pin[r_best];
            r_plvl <= r_lvl[r_best];
            r_sid  <= r_best;
            r_st   <= ST_OK;
            r_sact <= 1'b0;
        end
        if (i_ctl.age) begin
            for (int i = 0; i < SLOTS; i++)
                if (r_act[i])
                    r_tl[i] <= r_tl[i] - r_req.elapsed_ms;
        end
        if (i_ctl.idle_tick) begin
            r_wr   <= 1'b0;
            r_pout <= '0;
            r_plvl <= 1'b0;
            r_sid  <= '0;
            r_st   <= ST_OK;
            r_sact <= 1'b0;
        end
        if (i_ctl.min_step) begin
            r_idx <= r_idx + 1'b1;
            if (r_act[r_idx] && r_tl[r_idx] < r_min)
                r_min <= r_tl[r_idx];
        end
    end

    assign o_sts.cmd      = r_req.cmd;
    assign o_sts.found    = r_found && sel_ok;
    assign o_sts.any_due  = r_any;
    assign o_sts.scan_end = (r_idx == SLOT_W'(SLOTS - 1));
    assign o_rem = r_min;
    // pin_write, pin_out, pin_level, slot_id, status, any_expired, remaining_ms, slot_active
    assign o_res = {r_sact, r_min, r_any & r_wr, r_st, r_sid, r_plvl, r_pout, r_wr};

endmodule

@@ hw/rtl/mspt_controller.sv @@
// ----------------------------------------------------------------------------
// mspt_controller
// Sequencer: request decode, expiry walk, least-time scan, result handoff.
// ----------------------------------------------------------------------------
module mspt_controller (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    input  logic           i_res_ready,
    output logic           o_res_valid,
    output logic           o_res_last,
    input  mspt_pkg::t_sts i_sts,
    output mspt_pkg::t_ctl o_ctl
);
    import mspt_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_EXEC  = 9'b000000010,
        S_SCAN  = 9'b000000100,
        S_PICK  = 9'b000001000,
        S_MIN   = 9'b000010000,
        S_OUT   = 9'b000100000,
        S_AGE   = 9'b001000000,
        S_FMIN  = 9'b010000000,
        S_FOUT  = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        o_req_ready = 1'b0;
        o_res_valid = 1'b0;
        o_res_last  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_ctl.load = 1'b1;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.cmd == CMD_TICK) begin
                    o_ctl.scan_clr = 1'b1;
                    n_state = S_SCAN;
                end else begin
                    o_ctl.exec = 1'b1;
                    o_ctl.min_clr = 1'b1;
                    n_state = S_FMIN;
                end
            end
            S_SCAN: begin
                o_ctl.scan_step = 1'b1;
                if (i_sts.scan_end) n_state = S_PICK;
            end
            S_PICK: begin
                if (i_sts.found) begin
                    o_ctl.pick = 1'b1;
                    o_ctl.min_clr = 1'b1;
                    n_state = S_MIN;
                end else begin
                    if (!i_sts.any_due) o_ctl.idle_tick = 1'b1;
                    n_state = S_AGE;
                end
            end
            S_MIN: begin
                o_ctl.min_step = 1'b1;
                if (i_sts.scan_end) n_state = S_OUT;
            end
            S_OUT: begin
                // start another scan for the next due slot; the expiry is already queued
                o_ctl.scan_clr = 1'b1;
                n_state = S_SCAN;
            end
            S_AGE: begin
                o_ctl.age = 1'b1;
                o_ctl.min_clr = 1'b1;
                n_state = S_FMIN;
            end
            S_FMIN: begin
                o_ctl.min_step = 1'b1;
                if (i_sts.scan_end) n_state = S_FOUT;
            end
            S_FOUT: begin
                o_res_valid = 1'b1;
                o_res_last  = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ hw/rtl/mspt_out_queue.sv @@
// ----------------------------------------------------------------------------
// mspt_out_queue
// Result queue: holds the results of a request so remaining time can be patched.
// ----------------------------------------------------------------------------
module mspt_out_queue (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  logic [mspt_pkg::OUT_W-1:0]  i_res,
    input  logic                        i_final,
    input  logic [mspt_pkg::TIME_W-1:0] i_rem,
    output logic                        o_busy,
    output logic                        o_tvalid,
    input  logic                        i_tready,
    output logic [mspt_pkg::OUT_W-1:0]  o_res,
    output logic                        o_last
);
    import mspt_pkg::*;

    localparam int QW = $clog2(SLOTS + 1);
    localparam int RW = OUT_W;

    logic [RW-1:0]  r_q [SLOTS + 1];
    logic [QW-1:0]  r_cnt, r_head;
    logic           r_sealed;
    logic [TIME_W-1:0] r_rem;
    logic [RW-1:0]  head;

    assign head = r_q[r_head[QW-1:0]];
    assign o_busy   = r_sealed;
    assign o_tvalid = r_sealed && (r_head != r_cnt);
    assign o_last   = (r_head == r_cnt - 1'b1);
    assign o_res = {head[RW-1], r_rem, head[RW-2-TIME_W:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_head <= '0;
            r_sealed <= 1'b0;
        end else begin
            if (i_push) begin
                r_q[r_cnt] <= i_res;
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_final) begin
                r_sealed <= 1'b1;
                r_rem <= i_rem;
            end
            if (o_tvalid && i_tready) begin
                if (o_last) begin
                    r_cnt <= '0;
                    r_head <= '0;
                    r_sealed <= 1'b0;
                end else begin
                    r_head <= r_head + 1'b1;
                end
            end
        end
    end

endmodule

@@ hw/rtl/mspt_checker.sv @@
// ----------------------------------------------------------------------------
// mspt_port_checks
// Port-level checks of the pulse timer, bound to the top level.
// ----------------------------------------------------------------------------
module mspt_port_checks (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata,
    input logic        m_axis_tlast
);
    a_no_accept_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("request taken during output");
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second request taken while busy");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result dropped");
    a_write_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[9:1] == 9'd0)
        else $error("pin fields set without write");
    a_expired_writes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[15] |-> m_axis_tdata[0] && !m_axis_tdata[48])
        else $error("expiry without pin write");
endmodule

bind multi_slot_pulse_timer_unit mspt_port_checks u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
);

@@ verif/mspt_checker.sv @@
// ----------------------------------------------------------------------------
// mspt_checker
// Watches both channels of the pulse timer, predicts the results of each
// accepted request with its own slot table and compares them in order.
// ----------------------------------------------------------------------------
module mspt_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_req_valid,
    input  logic                             i_req_ready,
    input  logic [mspt_pkg::IN_BYTES_W-1:0]  i_req_data,
    input  logic                             i_rsp_valid,
    input  logic                             i_rsp_ready,
    input  logic [mspt_pkg::OUT_BYTES_W-1:0] i_rsp_data,
    input  logic                             i_rsp_last,
    output int                               o_errors,
    output int                               o_pending
);
    import mspt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic              last;
        logic              slot_active;
        logic [TIME_W-1:0] remaining_ms;
        logic              any_expired;
        logic [1:0]        status;
        logic [SLOT_W-1:0] slot_id;
        logic              pin_level;
        logic [PIN_W-1:0]  pin_out;
        logic              pin_write;
    } t_rsp;

    logic              armed   [SLOTS];
    logic [PIN_W-1:0]  pin_of  [SLOTS];
    logic              back_of [SLOTS];
    logic [TIME_W-1:0] left_of [SLOTS];
    t_rsp              pulse_q [$];
    int                errors;
    int                pending;

    assign o_errors  = errors;
    assign o_pending = pending;

    function automatic t_rsp mk(logic wr, logic [PIN_W-1:0] p, logic l,
                                logic [SLOT_W-1:0] s, logic [1:0] st,
                                logic ax, logic act);
        t_rsp r;
        r = '0;
        r.pin_write = wr; r.pin_out = p; r.pin_level = l; r.slot_id = s;
        r.status = st; r.any_expired = ax; r.slot_active = act;
        return r;
    endfunction

    task automatic predict_pulses(input logic [IN_BYTES_W-1:0] raw);
        t_req              rq;
        t_rsp              batch [$];
        logic              due [SLOTS];
        int                free_idx, best, ndue;
        logic [TIME_W-1:0] least;
        rq = {raw[1:0], raw[9:2], raw[10], raw[42:11], raw[45:43], raw[77:46]};
        case (rq.cmd)
            CMD_TRIGGER: begin
                if (rq.pulse_len == 0) begin
                    batch.push_back(mk(0, 0, 0, 0, ST_ZERO_DUR, 0, 0));
                end else begin
                    free_idx = -1;
                    for (int i = SLOTS - 1; i >= 0; i--) if (!armed[i]) free_idx = i;
                    if (free_idx < 0) begin
                        batch.push_back(mk(0, 0, 0, 0, ST_NO_SLOT, 0, 0));
                    end else begin
                        armed[free_idx]   = 1;
                        pin_of[free_idx]  = rq.pin;
                        back_of[free_idx] = ~rq.level;
                        left_of[free_idx] = rq.pulse_len;
                        batch.push_back(mk(1, rq.pin, rq.level, SLOT_W'(free_idx),
                                           ST_OK, 0, 0));
                    end
                end
            end
            CMD_CANCEL: begin
                if (armed[rq.slot]) begin
                    armed[rq.slot] = 0;
                    batch.push_back(mk(1, pin_of[rq.slot], back_of[rq.slot], rq.slot,
                                       ST_OK, 0, 0));
                end else begin
                    batch.push_back(mk(0, 0, 0, rq.slot, ST_INACTIVE, 0, 0));
                end
            end
            CMD_TICK: begin
                ndue = 0;
                for (int i = 0; i < SLOTS; i++) begin
                    due[i] = armed[i] && left_of[i] <= rq.elapsed_ms;
                    if (due[i]) ndue++;
                end
                while (ndue > 0) begin
                    best = -1;
                    for (int i = 0; i < SLOTS; i++)
                        if (due[i] && (best < 0 || left_of[i] < left_of[best])) best = i;
                    due[best] = 0;
                    ndue--;
                    armed[best] = 0;
                    batch.push_back(mk(1, pin_of[best], back_of[best], SLOT_W'(best),
                                       ST_OK, 1, 0));
                end
                for (int i = 0; i < SLOTS; i++)
                    if (armed[i]) left_of[i] -= rq.elapsed_ms;
                if (batch.size() == 0) batch.push_back(mk(0, 0, 0, 0, ST_OK, 0, 0));
            end
            default: begin
                batch.push_back(mk(0, 0, 0, rq.slot, ST_OK, 0, armed[rq.slot]));
            end
        endcase
        least = NONE_LEFT;
        for (int i = 0; i < SLOTS; i++)
            if (armed[i] && left_of[i] < least) least = left_of[i];
        foreach (batch[k]) begin
            batch[k].remaining_ms = least;
            batch[k].last = (k == batch.size() - 1);
            pulse_q.push_back(batch[k]);
        end
    endtask

    always @(posedge i_clk) begin
        t_rsp got, want;
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                armed[i] = 0; pin_of[i] = 0; back_of[i] = 0; left_of[i] = 0;
            end
            pulse_q.delete();
            errors = 0;
        end else begin
            if (i_req_valid && i_req_ready) predict_pulses(i_req_data);
            if (i_rsp_valid && i_rsp_ready) begin
                got = {i_rsp_last, i_rsp_data[48], i_rsp_data[47:16], i_rsp_data[15],
                       i_rsp_data[14:13], i_rsp_data[12:10], i_rsp_data[9],
                       i_rsp_data[8:1], i_rsp_data[0]};
                if (pulse_q.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected result %h", got);
                end else begin
                    want = pulse_q.pop_front();
                    if (got !== want) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: expected %h actual %h", want, got);
                    end
                end
            end
        end
        pending = pulse_q.size();
    end
endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Drives trigger, cancel, tick and query requests into the pulse timer with
// random gaps and output stalls; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb;
    import mspt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic                   i_clk = 0;
    logic                   i_rst_n = 0;
    logic                   s_axis_tvalid = 0;
    logic                   s_axis_tready;
    logic [IN_BYTES_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 0;
    logic [OUT_BYTES_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;
    int                     errors, pending;
    bit                     calm = 0;

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    multi_slot_pulse_timer_unit u_top (.*);

    mspt_checker u_chk (
        .i_clk, .i_rst_n,
        .i_req_valid(s_axis_tvalid), .i_req_ready(s_axis_tready), .i_req_data(s_axis_tdata),
        .i_rsp_valid(m_axis_tvalid), .i_rsp_ready(m_axis_tready), .i_rsp_data(m_axis_tdata),
        .i_rsp_last(m_axis_tlast), .o_errors(errors), .o_pending(pending)
    );

    initial begin
        int n;
        @(posedge i_clk);
        @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (calm || $urandom_range(0, 3) != 0) begin
                m_axis_tready <= 1;
            end else begin
                m_axis_tready <= 0;
                n = $urandom_range(1, 19);
                repeat (n - 1) @(posedge i_clk);
            end
        end
    end

    task automatic send(input logic [1:0] c, input logic [PIN_W-1:0] p, input logic l,
                        input logic [TIME_W-1:0] d, input logic [SLOT_W-1:0] s,
                        input logic [TIME_W-1:0] e);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 19);
            s_axis_tvalid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata  <= {{(IN_BYTES_W - IN_W){1'b0}}, e, s, d, l, p, c};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        @(posedge i_clk);
        wait (pending == 0);
    endtask

    function automatic logic [TIME_W-1:0] rtime();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 3);
            1: return $urandom_range(0, 200);
            2: return $urandom;
            default: return NONE_LEFT - $urandom_range(0, 2);
        endcase
    endfunction

    initial begin
        logic [PIN_W-1:0]  rp;
        logic              rl;
        logic [SLOT_W-1:0] rs;
        logic [TIME_W-1:0] rd, re;
        @(posedge i_clk);
        @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        send(CMD_QUERY, 0, 0, 0, 7, 0);
        send(CMD_TICK, 0, 0, 0, 0, 0);
        send(CMD_CANCEL, 0, 0, 0, 3, 0);
        send(CMD_TRIGGER, 8'hFF, 1, 0, 0, 0);
        send(CMD_TRIGGER, 8'hFF, 1, NONE_LEFT, 7, NONE_LEFT);
        send(CMD_TRIGGER, 8'h00, 0, 1, 0, 0);
        for (int i = 0; i < 6; i++) send(CMD_TRIGGER, PIN_W'(8'hA5 ^ i), i[0], 5, 0, 0);
        send(CMD_TRIGGER, 8'h12, 1, 9, 0, 0);
        send(CMD_QUERY, 0, 0, 0, 2, 0);
        send(CMD_CANCEL, 0, 0, 0, 4, 0);
        send(CMD_CANCEL, 0, 0, 0, 4, 0);
        send(CMD_TICK, 0, 0, 0, 0, 5);
        send(CMD_TICK, 0, 0, 0, 0, 0);
        send(CMD_TICK, 0, 0, 0, 0, NONE_LEFT);
        drain();
        for (int k = 0; k < 200; k++) begin
            if (k == 170) calm = 1;
            rp = PIN_W'($urandom);
            rl = 1'($urandom);
            rs = SLOT_W'($urandom);
            rd = $urandom;
            re = $urandom;
            case ($urandom_range(0, 9))
                0, 1, 2, 3: send(CMD_TRIGGER, rp, rl, rtime(), rs, re);
                4:          send(CMD_CANCEL, rp, rl, rd, rs, re);
                5, 6, 7:    send(CMD_TICK, rp, rl, rd, rs, rtime());
                default:    send(CMD_QUERY, rp, rl, rd, rs, re);
            endcase
            if (k == 100) drain();
        end
        drain();
        repeat (200) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end
endmodule

@@ filelist.f @@
hw/rtl/mspt_pkg.sv
hw/rtl/mspt_datapath.sv
hw/rtl/mspt_controller.sv
hw/rtl/mspt_out_queue.sv
hw/rtl/multi_slot_pulse_timer_unit.sv
hw/rtl/mspt_checker.sv
verif/mspt_checker.sv
verif/tb.sv
